// File: hdl/uitf_pkg.sv
// shared types, constants and checksum helper for the udp/ipv4 transmit framer
package uitf_pkg;

    // header layout constants
    localparam int unsigned HDR_BYTES     = 28;
    localparam int unsigned HDR_IDX_W     = $clog2(HDR_BYTES);
    localparam int unsigned UDP_HDR_BYTES = 8;
    localparam logic [7:0]  VER_IHL       = 8'h45;
    localparam logic [7:0]  IP_TTL        = 8'hff;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] PSEUDO_PROTO  = 16'h0011;

    // number of words the back end folds into the checksum per packet
    localparam int unsigned CK_TERMS  = 10;
    localparam int unsigned CK_STEP_W = $clog2(CK_TERMS + 1);

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // field widths
    localparam int unsigned ADDR_W = 11;
    localparam int unsigned LEN_W  = 11;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MY_IP    = 1'b0,
        CFG_SRC_PORT = 1'b1
    } cfg_index_t;

    // one input item
    typedef struct packed {
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        end_of_packet;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [ADDR_W-1:0] write_addr;
        logic [7:0]        write_byte;
        logic              packet_done;
        logic [LEN_W-1:0]  packet_length;
        logic              overflow;
    } out_item_t;

    // queue entry: a payload write, a packet end, or both
    typedef struct packed {
        logic              has_byte;
        logic              eop;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [31:0]       dest_ip;
        logic [15:0]       dest_port;
        logic [LEN_W-1:0]  plen;
        logic [15:0]       sum;
        logic [7:0]        held;
        logic              dropped;
    } q_entry_t;

    // one's complement 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

// File: hdl/uitf_queue.sv
// small register queue between the classifying front and the writing back
module uitf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  uitf_pkg::q_entry_t push_data,
    output logic              full,
    input  logic              pop,
    output uitf_pkg::q_entry_t pop_data,
    output logic              empty
);

    uitf_pkg::q_entry_t mem [uitf_pkg::QUEUE_DEPTH];

    logic [uitf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [uitf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [uitf_pkg::QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (uitf_pkg::QPTR_W + 1)'(uitf_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/uitf_front.sv
// front end: takes input transfers, numbers payload bytes and folds the payload checksum
module uitf_front #(
    parameter int MAX_PAYLOAD = 1472
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  uitf_pkg::in_item_t in_data,
    input  logic               q_full,
    output logic               push,
    output uitf_pkg::q_entry_t push_data
);

    logic [15:0]                  sum_reg;
    logic [7:0]                   held_reg;
    logic                         odd_reg;
    logic [uitf_pkg::LEN_W-1:0]   count_reg;
    logic [31:0]                  dip_reg;
    logic [15:0]                  dport_reg;
    logic                         in_pkt_reg;
    logic                         drop_reg;

    logic                         accept;
    logic                         active;
    logic                         take_byte;
    logic [15:0]                  sum_next;
    logic [7:0]                   held_next;
    logic                         odd_next;
    logic [uitf_pkg::LEN_W-1:0]   count_next;
    logic                         drop_next;
    logic [31:0]                  dip_cur;
    logic [15:0]                  dport_cur;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign active   = in_data.byte_valid || in_data.end_of_packet;
    assign take_byte = in_data.byte_valid
                       && (count_reg < uitf_pkg::LEN_W'(MAX_PAYLOAD));

    // destination of the current packet, latched on its first item
    assign dip_cur   = in_pkt_reg ? dip_reg   : in_data.dest_ip;
    assign dport_cur = in_pkt_reg ? dport_reg : in_data.dest_port;

    // payload byte folding into big-endian words
    always_comb
    begin
        sum_next   = sum_reg;
        held_next  = held_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        if (take_byte)
        begin
            if (odd_reg)
            begin
                sum_next  = uitf_pkg::oc_add(sum_reg, {held_reg, in_data.data_byte});
                held_next = 8'h00;
                odd_next  = 1'b0;
            end
            else
            begin
                held_next = in_data.data_byte;
                odd_next  = 1'b1;
            end
            count_next = count_reg + 1'b1;
        end
        drop_next = drop_reg || (in_data.byte_valid && !take_byte);
    end

    // queue entry for this transfer
    assign push = accept && (take_byte || in_data.end_of_packet);

    always_comb
    begin
        push_data.has_byte  = take_byte;
        push_data.eop       = in_data.end_of_packet;
        push_data.addr      = uitf_pkg::ADDR_W'(uitf_pkg::HDR_BYTES) + count_reg;
        push_data.data      = in_data.data_byte;
        push_data.dest_ip   = dip_cur;
        push_data.dest_port = dport_cur;
        push_data.plen      = count_next;
        push_data.sum       = sum_next;
        push_data.held      = held_next;
        push_data.dropped   = drop_next;
    end

    // packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            held_reg   <= '0;
            odd_reg    <= 1'b0;
            count_reg  <= '0;
            dip_reg    <= '0;
            dport_reg  <= '0;
            in_pkt_reg <= 1'b0;
            drop_reg   <= 1'b0;
        end
        else if (accept && active)
        begin
            if (in_data.end_of_packet)
            begin
                sum_reg    <= '0;
                held_reg   <= '0;
                odd_reg    <= 1'b0;
                count_reg  <= '0;
                in_pkt_reg <= 1'b0;
                drop_reg   <= 1'b0;
            end
            else
            begin
                sum_reg    <= sum_next;
                held_reg   <= held_next;
                odd_reg    <= odd_next;
                count_reg  <= count_next;
                in_pkt_reg <= 1'b1;
                drop_reg   <= drop_next;
            end
            dip_reg   <= dip_cur;
            dport_reg <= dport_cur;
        end
    end

endmodule

// File: hdl/uitf_back.sv
// back end: drains the queue into buffer writes and builds the 28-byte header
module uitf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  uitf_pkg::q_entry_t  q_data,
    input  logic                q_empty,
    output logic                pop,
    input  logic [31:0]         my_ip,
    input  logic [15:0]         src_port,
    output logic                out_valid,
    input  logic                out_ready,
    output uitf_pkg::out_item_t out_data
);

    typedef enum logic [1:0] {
        ST_FETCH = 2'b01,
        ST_HDR   = 2'b10
    } state_t;

    state_t                           state_reg, state_next;
    logic                             pay_sent_reg, pay_sent_next;
    logic                             out_valid_reg, out_valid_next;
    uitf_pkg::out_item_t              out_reg, out_next;
    logic [15:0]                      packet_id_reg, packet_id_next;
    logic [uitf_pkg::HDR_IDX_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [uitf_pkg::CK_STEP_W-1:0]   step_reg, step_next;
    logic [15:0]                      sum_reg, sum_next;

    // packet descriptor held during the header burst
    logic [31:0]                      dip_reg;
    logic [15:0]                      dport_reg;
    logic [uitf_pkg::LEN_W-1:0]       plen_reg;
    logic [7:0]                       held_reg;
    logic                             dropped_reg;

    logic                             load_ok;
    logic [uitf_pkg::LEN_W-1:0]       total_len;
    logic [15:0]                      udp_len;
    logic [15:0]                      ck;
    logic [15:0]                      term;
    logic [7:0]                       hdr_byte;
    logic                             hdr_last;

    assign load_ok   = !out_valid_reg || out_ready;
    assign total_len = plen_reg + uitf_pkg::LEN_W'(uitf_pkg::HDR_BYTES);
    assign udp_len   = 16'(plen_reg) + 16'(uitf_pkg::UDP_HDR_BYTES);
    assign ck        = ~sum_reg;
    assign hdr_last  = (hdr_idx_reg == uitf_pkg::HDR_IDX_W'(uitf_pkg::HDR_BYTES - 1));

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checksum word for the current fold step
    always_comb
    begin
        unique case (step_reg)
            4'd0:    term = {held_reg, 8'h00};
            4'd1:    term = my_ip[31:16];
            4'd2:    term = my_ip[15:0];
            4'd3:    term = dip_reg[31:16];
            4'd4:    term = dip_reg[15:0];
            4'd5:    term = uitf_pkg::PSEUDO_PROTO;
            4'd6:    term = udp_len;
            4'd7:    term = src_port;
            4'd8:    term = dport_reg;
            4'd9:    term = udp_len;
            default: term = 16'h0000;
        endcase
    end

    // header byte at the current offset
    always_comb
    begin
        unique case (hdr_idx_reg)
            5'd0:    hdr_byte = uitf_pkg::VER_IHL;
            5'd2:    hdr_byte = 8'(total_len >> 8);
            5'd3:    hdr_byte = total_len[7:0];
            5'd4:    hdr_byte = packet_id_reg[15:8];
            5'd5:    hdr_byte = packet_id_reg[7:0];
            5'd8:    hdr_byte = uitf_pkg::IP_TTL;
            5'd9:    hdr_byte = uitf_pkg::PROTO_UDP;
            5'd12:   hdr_byte = my_ip[31:24];
            5'd13:   hdr_byte = my_ip[23:16];
            5'd14:   hdr_byte = my_ip[15:8];
            5'd15:   hdr_byte = my_ip[7:0];
            5'd16:   hdr_byte = dip_reg[31:24];
            5'd17:   hdr_byte = dip_reg[23:16];
            5'd18:   hdr_byte = dip_reg[15:8];
            5'd19:   hdr_byte = dip_reg[7:0];
            5'd20:   hdr_byte = src_port[15:8];
            5'd21:   hdr_byte = src_port[7:0];
            5'd22:   hdr_byte = dport_reg[15:8];
            5'd23:   hdr_byte = dport_reg[7:0];
            5'd24:   hdr_byte = udp_len[15:8];
            5'd25:   hdr_byte = udp_len[7:0];
            5'd26:   hdr_byte = ck[15:8];
            5'd27:   hdr_byte = ck[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    // sequencer: payload writes, then header burst with checksum folding alongside
    always_comb
    begin
        state_next     = state_reg;
        pay_sent_next  = pay_sent_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        packet_id_next = packet_id_reg;
        hdr_idx_next   = hdr_idx_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_FETCH:
            begin
                if (!q_empty && load_ok)
                begin
                    if (q_data.has_byte && !pay_sent_reg)
                    begin
                        out_valid_next         = 1'b1;
                        out_next.write_addr    = q_data.addr;
                        out_next.write_byte    = q_data.data;
                        out_next.packet_done   = 1'b0;
                        out_next.packet_length = '0;
                        out_next.overflow      = 1'b0;
                        if (q_data.eop)
                        begin
                            pay_sent_next = 1'b1;
                        end
                        else
                        begin
                            pop = 1'b1;
                        end
                    end
                    else
                    begin
                        pop           = 1'b1;
                        pay_sent_next = 1'b0;
                        hdr_idx_next  = '0;
                        step_next     = '0;
                        sum_next      = q_data.sum;
                        state_next    = ST_HDR;
                    end
                end
            end
            ST_HDR:
            begin
                if (step_reg != uitf_pkg::CK_STEP_W'(uitf_pkg::CK_TERMS))
                begin
                    sum_next  = uitf_pkg::oc_add(sum_reg, term);
                    step_next = step_reg + 1'b1;
                end
                if (load_ok)
                begin
                    out_valid_next         = 1'b1;
                    out_next.write_addr    = uitf_pkg::ADDR_W'(hdr_idx_reg);
                    out_next.write_byte    = hdr_byte;
                    out_next.packet_done   = hdr_last;
                    out_next.packet_length = hdr_last ? total_len : '0;
                    out_next.overflow      = hdr_last && dropped_reg;
                    hdr_idx_next           = hdr_idx_reg + 1'b1;
                    if (hdr_last)
                    begin
                        packet_id_next = packet_id_reg + 1'b1;
                        state_next     = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FETCH;
            pay_sent_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            packet_id_reg <= '0;
            hdr_idx_reg   <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pay_sent_reg  <= pay_sent_next;
            out_valid_reg <= out_valid_next;
            packet_id_reg <= packet_id_next;
            hdr_idx_reg   <= hdr_idx_next;
            step_reg      <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sum_reg <= sum_next;
        if (state_reg == ST_FETCH && pop && q_data.eop)
        begin
            dip_reg     <= q_data.dest_ip;
            dport_reg   <= q_data.dest_port;
            plen_reg    <= q_data.plen;
            held_reg    <= q_data.held;
            dropped_reg <= q_data.dropped;
        end
    end

endmodule

// File: hdl/udp_ipv4_tx_framer_unit.sv
// top level of the udp/ipv4 transmit framer: configuration registers and the front, queue, back
//
//  channel | direction | handshake              | carries
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid / in_ready    | in_item_t: destination, payload byte
//  out     | output    | out_valid / out_ready  | out_item_t: buffer write, packet end
//  cfg     | input     | cfg_wr_en (no wait)    | cfg_index, cfg_wdata
//
// payload bytes pass through the front and then the back and stream at one per cycle while
// out_ready holds; each packet end adds a 28-byte header burst after loading the descriptor.
// the checksum fold of the header words runs in the back alongside the first header bytes.
// the four-entry queue lets the front keep taking transfers while the back is in a burst.
// reset clears all control state; configuration registers reset to zero.
module udp_ipv4_tx_framer_unit #(
    parameter int MAX_PAYLOAD = 1472
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  uitf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output uitf_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);

    logic [31:0]        my_ip_reg;
    logic [15:0]        src_port_reg;

    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    uitf_pkg::q_entry_t q_push_data;
    uitf_pkg::q_entry_t q_pop_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_ip_reg    <= '0;
            src_port_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (uitf_pkg::cfg_index_t'(cfg_index))
                uitf_pkg::CFG_MY_IP:    my_ip_reg    <= cfg_wdata;
                uitf_pkg::CFG_SRC_PORT: src_port_reg <= cfg_wdata[15:0];
                default:                my_ip_reg    <= my_ip_reg;
            endcase
        end
    end

    // input side
    uitf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // decoupling queue
    uitf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // output side
    uitf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_pop_data),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .my_ip     (my_ip_reg),
        .src_port  (src_port_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
